FILE: rtl/cle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor package
// Shared sizes, key codes, the command and result records and the ring index
// helpers used by the front end, the command queue and the back end.
// ----------------------------------------------------------------------------
package cle_pkg;

	localparam int LINE_DEPTH = 128;
	localparam int RING_SPAN  = 2 * LINE_DEPTH;
	localparam int IDX_W      = $clog2(RING_SPAN);
	localparam int SLOT_W     = $clog2(LINE_DEPTH);

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [SLOT_W-1:0] slot_t;

	localparam idx_t DEPTH_IDX = idx_t'(LINE_DEPTH);
	localparam idx_t SPAN_MAX  = idx_t'(RING_SPAN - 1);

	localparam logic [7:0] KEY_UP    = 8'd226;
	localparam logic [7:0] KEY_DOWN  = 8'd227;
	localparam logic [7:0] KEY_LEFT  = 8'd228;
	localparam logic [7:0] KEY_RIGHT = 8'd229;
	localparam logic [7:0] KEY_DEL   = 8'd127;
	localparam logic [7:0] CTL_H     = 8'd8;
	localparam logic [7:0] CTL_U     = 8'd21;
	localparam logic [7:0] CTL_D     = 8'd4;
	localparam logic [7:0] CTL_P     = 8'd16;
	localparam logic [7:0] KEY_CR    = 8'd13;
	localparam logic [7:0] KEY_NL    = 8'd10;
	localparam logic [7:0] KEY_NONE  = 8'd0;
	localparam logic [7:0] ERASE_MAX = 8'hFF;

	localparam logic OP_KEY  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef enum logic [3:0] {
		CMD_NOP,
		CMD_DUMP,
		CMD_KILL,
		CMD_BKSP,
		CMD_ECHO,
		CMD_LEFT,
		CMD_RIGHT,
		CMD_CHAR,
		CMD_NL,
		CMD_READ
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t   kind;
		logic [7:0]  code;
		logic        has_data;
	} cmd_t;

	typedef struct packed {
		logic        echo_valid;
		logic [7:0]  echo_code;
		logic [7:0]  erase_count;
		logic        line_committed;
		logic        dump_request;
		logic        read_valid;
		logic [7:0]  read_byte;
		logic        read_eof;
	} res_t;

	function automatic idx_t ring_inc(idx_t x);
		return (x == SPAN_MAX) ? '0 : idx_t'(x + 1'b1);
	endfunction

	function automatic idx_t ring_dec(idx_t x);
		return (x == '0) ? SPAN_MAX : idx_t'(x - 1'b1);
	endfunction

	function automatic idx_t ring_dist(idx_t a, idx_t b);
		logic [IDX_W:0] wide;
		wide = {1'b0, a} + (IDX_W+1)'(RING_SPAN) - {1'b0, b};
		return (a >= b) ? idx_t'(a - b) : wide[IDX_W-1:0];
	endfunction

	function automatic slot_t slot(idx_t x);
		return (x >= DEPTH_IDX) ? slot_t'(x - DEPTH_IDX) : slot_t'(x);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/cle_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor front end
// Accepts requests, decodes each key code or read access into a command and
// holds it in a register stage until the command queue takes it.
// ----------------------------------------------------------------------------
module cle_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          opcode,
	input  wire logic [7:0]    key_code,
	input  wire logic          reader_has_data,
	output logic               cmd_valid,
	output cle_pkg::cmd_t      cmd,
	input  wire logic          cmd_ready
);
	import cle_pkg::*;

	logic valid_s1;
	cmd_t cmd_s1;
	cmd_t decoded;

	always_comb begin
		decoded          = '0;
		decoded.code     = key_code;
		decoded.has_data = reader_has_data;
		if (opcode == OP_READ) begin
			decoded.kind = CMD_READ;
		end else begin
			case (key_code)
				KEY_NONE:           decoded.kind = CMD_NOP;
				CTL_P:              decoded.kind = CMD_DUMP;
				CTL_U:              decoded.kind = CMD_KILL;
				CTL_H, KEY_DEL:     decoded.kind = CMD_BKSP;
				KEY_UP, KEY_DOWN:   decoded.kind = CMD_ECHO;
				KEY_LEFT:           decoded.kind = CMD_LEFT;
				KEY_RIGHT:          decoded.kind = CMD_RIGHT;
				KEY_CR, KEY_NL: begin
					decoded.kind = CMD_NL;
					decoded.code = KEY_NL;
				end
				default:            decoded.kind = CMD_CHAR;
			endcase
		end
	end

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= decoded;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/cle_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor command queue
// Two-entry queue that decouples command decoding from command execution.
// ----------------------------------------------------------------------------
module cle_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push_valid,
	output logic               push_ready,
	input  wire cle_pkg::cmd_t push_cmd,
	output logic               pop_valid,
	output cle_pkg::cmd_t      pop_cmd,
	input  wire logic          pop_ready
);
	import cle_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push;
	logic       do_pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid  = (count_q != 2'd0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/cle_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor back end
// Executes commands against the ring line store: shifts for insert and
// delete one entry per cycle, walks back over the line for kill, pops bytes
// for reads, and holds each result in an output register.
// ----------------------------------------------------------------------------
module cle_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	input  wire cle_pkg::cmd_t cmd,
	output logic               cmd_ready,
	output logic               out_valid,
	output cle_pkg::res_t      out_res,
	input  wire logic          out_ready
);
	import cle_pkg::*;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_KILL = 7'b0000010,
		ST_SHR  = 7'b0000100,
		ST_PUT  = 7'b0001000,
		ST_SHL  = 7'b0010000,
		ST_RDW  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t st_q, st_d;
	cmd_t   cmd_q, cmd_d;
	res_t   res_q, res_d;
	res_t   out_res_q;
	logic   out_valid_q;
	logic   out_load;
	idx_t   rd_q, rd_d;
	idx_t   commit_q, commit_d;
	idx_t   cur_q, cur_d;
	idx_t   end_q, end_d;
	idx_t   wp_q, wp_d;

	idx_t   cur_inc, cur_dec, end_inc, end_dec, rd_inc, wn_inc, wn_dec;
	logic   full;

	logic [7:0] line_mem [LINE_DEPTH];
	logic [7:0] mem_rdata_q;
	logic       mem_re, mem_we;
	slot_t      mem_raddr, mem_waddr;
	logic [7:0] mem_wdata;

	assign cur_inc = ring_inc(cur_q);
	assign cur_dec = ring_dec(cur_q);
	assign end_inc = ring_inc(end_q);
	assign end_dec = ring_dec(end_q);
	assign rd_inc  = ring_inc(rd_q);
	assign wn_inc  = ring_inc(wp_q);
	assign wn_dec  = ring_dec(wp_q);
	assign full    = (ring_dist(end_q, rd_q) >= DEPTH_IDX);

	always_comb begin
		st_d      = st_q;
		cmd_d     = cmd_q;
		res_d     = res_q;
		rd_d      = rd_q;
		commit_d  = commit_q;
		cur_d     = cur_q;
		end_d     = end_q;
		wp_d      = wp_q;
		cmd_ready = 1'b0;
		out_load  = 1'b0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		case (st_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					cmd_ready = 1'b1;
					cmd_d     = cmd;
					res_d     = '0;
					st_d      = ST_FIN;
					case (cmd.kind)
						CMD_DUMP: res_d.dump_request = 1'b1;
						CMD_ECHO: begin
							res_d.echo_valid = 1'b1;
							res_d.echo_code  = cmd.code;
						end
						CMD_LEFT: begin
							if (cur_q != commit_q) begin
								cur_d            = cur_dec;
								res_d.echo_valid = 1'b1;
								res_d.echo_code  = cmd.code;
							end
						end
						CMD_RIGHT: begin
							if (cur_q != end_q) begin
								cur_d            = cur_inc;
								res_d.echo_valid = 1'b1;
								res_d.echo_code  = cmd.code;
							end
						end
						CMD_KILL: begin
							mem_re    = 1'b1;
							mem_raddr = slot(end_dec);
							st_d      = ST_KILL;
						end
						CMD_BKSP: begin
							if (cur_q != commit_q) begin
								cur_d             = cur_dec;
								end_d             = end_dec;
								res_d.erase_count = 8'd1;
								if (cur_dec != end_dec) begin
									wp_d      = cur_dec;
									mem_re    = 1'b1;
									mem_raddr = slot(cur_q);
									st_d      = ST_SHL;
								end
							end
						end
						CMD_CHAR: begin
							if (!full) begin
								if (end_q == cur_q) begin
									st_d = ST_PUT;
								end else begin
									wp_d      = end_q;
									mem_re    = 1'b1;
									mem_raddr = slot(end_dec);
									st_d      = ST_SHR;
								end
							end
						end
						CMD_NL: begin
							if (!full) begin
								mem_we               = 1'b1;
								mem_waddr            = slot(end_q);
								mem_wdata            = KEY_NL;
								end_d                = end_inc;
								commit_d             = end_inc;
								cur_d                = end_inc;
								res_d.echo_valid     = 1'b1;
								res_d.echo_code      = KEY_NL;
								res_d.line_committed = 1'b1;
							end
						end
						CMD_READ: begin
							if (rd_q != commit_q) begin
								mem_re    = 1'b1;
								mem_raddr = slot(rd_q);
								st_d      = ST_RDW;
							end
						end
						default: st_d = ST_FIN;
					endcase
				end
			end
			ST_KILL: begin
				if (end_q == commit_q || mem_rdata_q == KEY_NL) begin
					cur_d = end_q;
					st_d  = ST_FIN;
				end else begin
					end_d = end_dec;
					if (res_q.erase_count != ERASE_MAX) begin
						res_d.erase_count = res_q.erase_count + 8'd1;
					end
					mem_re    = 1'b1;
					mem_raddr = slot(ring_dec(end_dec));
				end
			end
			ST_SHR: begin
				mem_we    = 1'b1;
				mem_waddr = slot(wp_q);
				mem_wdata = mem_rdata_q;
				if (wn_dec == cur_q) begin
					st_d = ST_PUT;
				end else begin
					wp_d      = wn_dec;
					mem_re    = 1'b1;
					mem_raddr = slot(ring_dec(wn_dec));
				end
			end
			ST_PUT: begin
				mem_we           = 1'b1;
				mem_waddr        = slot(cur_q);
				mem_wdata        = cmd_q.code;
				cur_d            = cur_inc;
				end_d            = end_inc;
				res_d.echo_valid = 1'b1;
				res_d.echo_code  = cmd_q.code;
				if (cmd_q.code == CTL_D || ring_dist(end_inc, rd_q) == DEPTH_IDX) begin
					commit_d             = end_inc;
					cur_d                = end_inc;
					res_d.line_committed = 1'b1;
				end
				st_d = ST_FIN;
			end
			ST_SHL: begin
				mem_we    = 1'b1;
				mem_waddr = slot(wp_q);
				mem_wdata = mem_rdata_q;
				if (wn_inc == end_q) begin
					st_d = ST_FIN;
				end else begin
					wp_d      = wn_inc;
					mem_re    = 1'b1;
					mem_raddr = slot(ring_inc(wn_inc));
				end
			end
			ST_RDW: begin
				res_d.read_valid = 1'b1;
				if (mem_rdata_q == CTL_D) begin
					res_d.read_eof = 1'b1;
					if (!cmd_q.has_data) begin
						rd_d = rd_inc;
					end
				end else begin
					res_d.read_byte = mem_rdata_q;
					rd_d            = rd_inc;
				end
				st_d = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					st_d     = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rd_q        <= '0;
			commit_q    <= '0;
			cur_q       <= '0;
			end_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			rd_q     <= rd_d;
			commit_q <= commit_d;
			cur_q    <= cur_d;
			end_q    <= end_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		res_q <= res_d;
		wp_q  <= wp_d;
		if (out_load) begin
			out_res_q <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			line_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= line_mem[mem_raddr];
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

endmodule
`default_nettype wire

FILE: rtl/console_line_editor_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Console line editor
// Canonical-mode line editing over a ring line store with a read-out port.
//
// One request (opcode, key_code, reader_has_data) enters on the input
// channel; exactly one result leaves on the output channel for every request,
// in order. A front end decodes requests into a two-entry command queue, and
// the back end executes one command at a time against the line store memory.
// An insert or a delete shifts the line one store entry per cycle, and a
// kill-line walks back one entry per cycle; the memory's single read and
// write port per cycle sets these rates. The back end takes a new command
// only in ST_IDLE, after the last result has been handed over in ST_FIN.
// The front end keeps accepting requests until the queue and its register
// are full, also while a result waits. When the receiver stalls, the result
// stays in the output register and the back end waits with the next one.
// Reset clears the read, commit, cursor and end indices, so the line is
// empty; the store itself is not cleared.
// ----------------------------------------------------------------------------
module console_line_editor_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic       opcode,
	input  wire logic [7:0] key_code,
	input  wire logic       reader_has_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            echo_valid,
	output logic [7:0]      echo_code,
	output logic [7:0]      erase_count,
	output logic            line_committed,
	output logic            dump_request,
	output logic            read_valid,
	output logic [7:0]      read_byte,
	output logic            read_eof
);
	import cle_pkg::*;

	logic front_valid, front_ready;
	cmd_t front_cmd;
	logic queue_valid, queue_ready;
	cmd_t queue_cmd;
	res_t res;

	cle_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.opcode          (opcode),
		.key_code        (key_code),
		.reader_has_data (reader_has_data),
		.cmd_valid       (front_valid),
		.cmd             (front_cmd),
		.cmd_ready       (front_ready)
	);

	cle_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (front_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (queue_valid),
		.pop_cmd    (queue_cmd),
		.pop_ready  (queue_ready)
	);

	cle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (queue_valid),
		.cmd       (queue_cmd),
		.cmd_ready (queue_ready),
		.out_valid (out_valid),
		.out_res   (res),
		.out_ready (out_ready)
	);

	assign echo_valid     = res.echo_valid;
	assign echo_code      = res.echo_code;
	assign erase_count    = res.erase_count;
	assign line_committed = res.line_committed;
	assign dump_request   = res.dump_request;
	assign read_valid     = res.read_valid;
	assign read_byte      = res.read_byte;
	assign read_eof       = res.read_eof;

endmodule
`default_nettype wire
